// ===== rtl/core/mcmd_pkg.sv =====
// Package for the math coprocessor: register offsets and the command and
// status structs between controller and datapath. No dependencies.
package mcmd_pkg;

  localparam logic [7:0] OFF_D   = 8'h52;
  localparam logic [7:0] OFF_C   = 8'h53;
  localparam logic [7:0] OFF_A   = 8'h55;
  localparam logic [7:0] OFF_H   = 8'h60;
  localparam logic [7:0] OFF_E   = 8'h63;
  localparam logic [7:0] OFF_M   = 8'h6c;
  localparam logic [7:0] OFF_SYS = 8'h92;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic [7:0] offset;
    logic [7:0] data;
    logic       mul_go;
    logic       div_go;
    logic       div_step;
    logic       div_done;
  } cmd_t;

  typedef struct packed {
    logic       start_div;
  } status_t;

endpackage

// ===== rtl/core/math_coprocessor_mul_div.sv =====
// Math coprocessor with 16x16 multiply/accumulate and 32/16 divide.
// Byte register accesses arrive on the s_axis channel; each transaction
// returns exactly one byte on the m_axis channel (zero for writes).
// s_axis_tdata: mode, offset, write_byte from bit 0 up, padded to 24 bits.
// m_axis_tdata: read_byte.
// The result is registered on acceptance.
// Throughput: one access per cycle while the receiver keeps up, except that no
// access is accepted while a multiply or divide that an access started runs;
// the bit-serial divider produces one quotient bit per cycle.
// Reset (rst, synchronous) clears all register bytes, flags and modes to zero.
// While the receiver stalls, the pending result holds and no new transaction
// is accepted. Depends on mcmd_pkg, mcmd_ctrl and mcmd_datapath.
module math_coprocessor_mul_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // mode, offset, write_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // read_byte
);

  mcmd_pkg::cmd_t    cmd;
  mcmd_pkg::status_t status;

  mcmd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[16:0]), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .status(status), .cmd(cmd)
  );

  mcmd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .rdata(m_axis_tdata)
  );

endmodule

// ===== rtl/core/mcmd_datapath.sv =====
// Datapath of the math coprocessor: register bytes, multiply/accumulate and a
// restoring bit-serial divider. Depends on mcmd_pkg.
module mcmd_datapath (
  input  logic             clk,
  input  logic             rst,
  input  mcmd_pkg::cmd_t   cmd,
  output mcmd_pkg::status_t status,
  output logic [7:0]       rdata
);

  logic [7:0] mb [14];
  logic sign_first, sign_second, signed_mode, accumulate_mode, overflow_flag;
  logic vstretch, lefthand;
  logic [3:0] slot;
  logic       hit;
  logic [15:0] left, right, fac, fdec, fneg;
  logic [31:0] prod, prodn, acc, num_r;
  logic [32:0] sum;
  logic [15:0] rem, den;
  logic [16:0] trial;
  logic [31:0] quo;

  always_comb begin
    hit = 1'b1;
    slot = 4'd0;
    if (cmd.offset >= 8'h52 && cmd.offset <= 8'h57) slot = 4'(cmd.offset - 8'h52);
    else if (cmd.offset >= 8'h60 && cmd.offset <= 8'h63) slot = 4'(cmd.offset - 8'h5a);
    else if (cmd.offset >= 8'h6c && cmd.offset <= 8'h6f) slot = 4'(cmd.offset - 8'h62);
    else hit = 1'b0;
  end

  assign status.start_div = cmd.load && cmd.wr && cmd.offset == mcmd_pkg::OFF_E;
  assign left  = {mb[3], mb[2]};
  assign right = {mb[1], mb[0]};
  assign prod  = left * right;
  assign prodn = (signed_mode && (sign_first != sign_second)) ? -prod : prod;
  assign acc   = {mb[13], mb[12], mb[11], mb[10]};
  assign sum   = {1'b0, acc} + {1'b0, prodn};
  assign den   = {mb[5], mb[4]};
  assign trial = {rem, num_r[31]} - {1'b0, den};
  assign fac   = {cmd.data, (cmd.offset == mcmd_pkg::OFF_C) ? mb[0] : mb[2]};
  assign fdec  = fac - 16'd1;
  assign fneg  = -fac;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 14; i++) mb[i] <= 8'd0;
      sign_first <= 1'b0;
      sign_second <= 1'b0;
      signed_mode <= 1'b0;
      accumulate_mode <= 1'b0;
      overflow_flag <= 1'b0;
      vstretch <= 1'b0;
      lefthand <= 1'b0;
      rdata <= 8'd0;
    end else begin
      if (cmd.load) begin
        rdata <= 8'd0;
        if (!cmd.wr) begin
          if (hit) rdata <= mb[slot];
          else if (cmd.offset == mcmd_pkg::OFF_SYS)
            rdata <= {1'b0, overflow_flag, 1'b0, vstretch, lefthand, 3'b000};
        end else if (hit) begin
          mb[slot] <= cmd.data;
          if (!cmd.offset[0]) mb[slot + 4'd1] <= 8'd0;
          if (cmd.offset == mcmd_pkg::OFF_M) overflow_flag <= 1'b0;
          if (cmd.offset == mcmd_pkg::OFF_D && cmd.data != 8'd0) sign_second <= 1'b0;
          if (cmd.offset == mcmd_pkg::OFF_C && signed_mode) begin
            sign_second <= fdec[15];
            if (fdec[15]) {mb[1], mb[0]} <= fneg;
          end
          if (cmd.offset == mcmd_pkg::OFF_A && signed_mode) begin
            sign_first <= fdec[15];
            if (fdec[15]) {mb[3], mb[2]} <= fneg;
          end
        end else if (cmd.offset == mcmd_pkg::OFF_SYS) begin
          signed_mode <= cmd.data[7];
          accumulate_mode <= cmd.data[6];
          vstretch <= cmd.data[4];
          lefthand <= cmd.data[3];
        end
      end
      if (cmd.mul_go) begin
        overflow_flag <= accumulate_mode & sum[32];
        {mb[9], mb[8], mb[7], mb[6]} <= prodn;
        if (accumulate_mode) {mb[13], mb[12], mb[11], mb[10]} <= sum[31:0];
      end
      if (cmd.div_go) begin
        num_r <= {mb[9], mb[8], mb[7], mb[6]};
        rem <= 16'd0;
      end
      if (cmd.div_step) begin
        num_r <= {num_r[30:0], 1'b0};
        quo <= {quo[30:0], !trial[16]};
        rem <= trial[16] ? {rem[14:0], num_r[31]} : trial[15:0];
      end
      if (cmd.div_done) begin
        overflow_flag <= den == 16'd0;
        {mb[3], mb[2], mb[1], mb[0]} <= (den == 16'd0) ? 32'hffffffff : quo;
        {mb[13], mb[12], mb[11], mb[10]} <= (den == 16'd0) ? 32'd0 : {16'd0, rem};
      end
    end
  end

endmodule

// ===== rtl/core/mcmd_ctrl.sv =====
// Controller of the math coprocessor: handshake and multiply and divide sequencing.
// Depends on mcmd_pkg; drives mcmd_datapath.
module mcmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [16:0]       in_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  mcmd_pkg::status_t status,
  output mcmd_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0] state, state_next;
  logic [5:0] count;
  logic       acc;

  assign in_ready = state == S_IDLE && (!out_valid || out_ready);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load = acc;
    cmd.wr = in_data[0];
    cmd.offset = in_data[8:1];
    cmd.data = in_data[16:9];
    cmd.mul_go = state == S_MUL;
    cmd.div_step = state == S_DIV && count != 6'd0;
    cmd.div_go = state == S_DIV && count == 6'd0;
    cmd.div_done = state == S_FIN;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && in_data[0] && in_data[8:1] == mcmd_pkg::OFF_A) state_next = S_MUL;
        else if (status.start_div) state_next = S_DIV;
      end
      S_DIV:  if (count == 6'd32) state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      S_MUL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= (state == S_DIV) ? count + 6'd1 : 6'd0;
      if (acc) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst) state != S_DIV |-> count == 6'd0 ||
    $past(state) == S_DIV) else $error("count not cleared");
  a_nordy: assert property (@(posedge clk) disable iff (rst) state != S_IDLE |-> !in_ready)
    else $error("ready while busy");
  a_fin: assert property (@(posedge clk) disable iff (rst) state == S_FIN |=> state == S_IDLE)
    else $error("finish not single cycle");
`endif

endmodule
